### rtl/prs_pkg.sv
// Package for the probe reply statistics block.
// Holds the event codes, reply status codes and fixed field widths.
// No dependencies.
package prs_pkg;

    // Fixed widths of the input fields and of the loss field
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int RTT_IN_W = 24;
    localparam int LOSS_W   = 7;

    // Loss is reported in percent
    localparam int PCT_SCALE = 100;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // Event kinds
    localparam t_cmd CMD_SENT   = 2'd0;
    localparam t_cmd CMD_REPLY  = 2'd1;
    localparam t_cmd CMD_SAMPLE = 2'd2;
    localparam t_cmd CMD_NONE   = 2'd3;

    // Reply classes; any other code counts as a first answer
    localparam t_status ST_FIRST     = 2'd0;
    localparam t_status ST_DUP       = 2'd1;
    localparam t_status ST_UNMATCHED = 2'd2;

endpackage

### rtl/probe_reply_statistics_top.sv
// Probe reply statistics: saturating probe and reply counters, loss percent and
// running round trip minimum, mean and maximum, with one bit-serial divider.
// Depends on prs_pkg.
//
//  channel  dir  handshake              payload (low bit first)
//  s        in   i_s_tvalid/o_s_tready  tuser: cmd[1:0], reply_status[3:2]
//                                       tdata: rtt_ms[23:0]
//  m        out  o_m_tvalid/i_m_tready  tdata: sent_total, received_total,
//                                       duplicate_total, unmatched_total,
//                                       unique_replies, loss_pct, rtt_valid,
//                                       rtt_minimum, rtt_mean, rtt_maximum
//
// The divider is a restoring unit that retires one quotient bit per cycle from a
// dividend of DW = max(COUNT_WIDTH + 7, RTT_WIDTH) bits (39 at the defaults).
// A probe or reply event runs the unique count, difference, scaling, division
// and output steps, a round trip sample division and output, an unused command
// output only; loss needs no division when nothing is lost or nothing was sent.
// One item is in work at a time; the output register holds a finished result
// while the next item is accepted, and a stalled output holds the block in its
// final step. Reset is synchronous and clears all counters and statistics.
module probe_reply_statistics_top #(
    parameter int COUNT_WIDTH = 32,
    parameter int RTT_WIDTH   = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input item
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [prs_pkg::RTT_IN_W-1:0]  i_s_tdata,  // rtt_ms
    input  logic [3:0]                    i_s_tuser,  // cmd, reply_status
    // result item
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // sent_total, received_total, duplicate_total, unmatched_total,
    // unique_replies, loss_pct, rtt_valid, rtt_minimum, rtt_mean, rtt_maximum
    output logic [((5*COUNT_WIDTH+prs_pkg::LOSS_W+1+3*RTT_WIDTH+7)/8)*8-1:0] o_m_tdata
);

    localparam int OUT_TW = ((5*COUNT_WIDTH + prs_pkg::LOSS_W + 1 + 3*RTT_WIDTH + 7) / 8) * 8;
    localparam int DW     = (COUNT_WIDTH + 7 > RTT_WIDTH) ? COUNT_WIDTH + 7 : RTT_WIDTH;
    localparam int STEPW  = $clog2(DW);

    // Sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UNQ1  = 3'd1;
    localparam logic [2:0] S_UNQ2  = 3'd2;
    localparam logic [2:0] S_DIFF  = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]               r_state;
    logic                     r_ovalid;
    logic [COUNT_WIDTH-1:0]   r_sent, r_recv, r_dup, r_unm, r_samples, r_uniq;
    logic [prs_pkg::LOSS_W-1:0] r_loss;
    logic [RTT_WIDTH-1:0]     r_min, r_max, r_mean;

    // divider datapath
    logic [DW-1:0]            r_dvd;
    logic [COUNT_WIDTH-1:0]   r_rem, r_dsr, r_tmp;
    logic [STEPW-1:0]         r_step;
    logic                     r_is_mean, r_neg;
    logic [OUT_TW-1:0]        r_out;

    logic                     w_acc;
    prs_pkg::t_cmd            w_cmd;
    prs_pkg::t_status         w_status;
    logic [RTT_WIDTH+prs_pkg::RTT_IN_W-1:0] w_rtt_ext;
    logic [RTT_WIDTH-1:0]     w_rtt, w_mag;
    logic [COUNT_WIDTH-1:0]   w_samples_inc;
    logic [COUNT_WIDTH:0]     n_trial, n_diff;
    logic                     n_qbit;
    logic [COUNT_WIDTH-1:0]   n_rem;
    logic [DW-1:0]            n_dvd;
    logic [RTT_WIDTH-1:0]     n_quot;
    logic                     w_out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_cmd      = i_s_tuser[prs_pkg::CMD_W-1:0];
    assign w_status   = i_s_tuser[prs_pkg::CMD_W+prs_pkg::STATUS_W-1:prs_pkg::CMD_W];

    // Keep only the low RTT_WIDTH bits of the sample
    assign w_rtt_ext  = {{RTT_WIDTH{1'b0}}, i_s_tdata};
    assign w_rtt      = w_rtt_ext[RTT_WIDTH-1:0];
    assign w_mag      = (w_rtt >= r_mean) ? (w_rtt - r_mean) : (r_mean - w_rtt);
    assign w_samples_inc = (&r_samples) ? r_samples : r_samples + 1'b1;

    // One restoring division step
    assign n_trial = {r_rem, r_dvd[DW-1]};
    assign n_diff  = n_trial - {1'b0, r_dsr};
    assign n_qbit  = (n_trial >= {1'b0, r_dsr});
    assign n_rem   = n_qbit ? n_diff[COUNT_WIDTH-1:0] : n_trial[COUNT_WIDTH-1:0];
    assign n_dvd   = {r_dvd[DW-2:0], n_qbit};
    assign n_quot  = n_dvd[RTT_WIDTH-1:0];

    assign w_out_free = !r_ovalid || i_m_tready;

    // Sequencer, counters and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_sent    <= '0;
            r_recv    <= '0;
            r_dup     <= '0;
            r_unm     <= '0;
            r_samples <= '0;
            r_uniq    <= '0;
            r_loss    <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_mean    <= '0;
        end else begin
            // raise valid on a new result, drop it once taken
            r_ovalid <= (r_state == S_OUT && w_out_free) || (r_ovalid && !i_m_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (w_cmd)
                            prs_pkg::CMD_SENT: begin
                                if (!(&r_sent)) r_sent <= r_sent + 1'b1;
                                r_state <= S_UNQ1;
                            end
                            prs_pkg::CMD_REPLY: begin
                                if (!(&r_recv)) r_recv <= r_recv + 1'b1;
                                if (w_status == prs_pkg::ST_DUP && !(&r_dup)) begin
                                    r_dup <= r_dup + 1'b1;
                                end
                                if (w_status == prs_pkg::ST_UNMATCHED && !(&r_unm)) begin
                                    r_unm <= r_unm + 1'b1;
                                end
                                r_state <= S_UNQ1;
                            end
                            prs_pkg::CMD_SAMPLE: begin
                                if (r_samples == '0 || w_rtt < r_min) r_min <= w_rtt;
                                if (r_samples == '0 || w_rtt > r_max) r_max <= w_rtt;
                                r_samples <= w_samples_inc;
                                r_state   <= S_DIV;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_UNQ1:  r_state <= S_UNQ2;
                S_UNQ2: begin
                    r_uniq  <= (r_unm >= r_tmp) ? '0 : r_tmp - r_unm;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    // nothing sent or nothing lost: no division
                    if (r_sent == '0 || r_uniq >= r_sent) begin
                        r_loss  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_DIV;
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // retire the quotient, last bit included, after the last step
            if (r_state == S_DIV && r_step == '0) begin
                if (r_is_mean) begin
                    r_mean <= r_neg ? r_mean - n_quot : r_mean + n_quot;
                end else begin
                    r_loss <= n_dvd[prs_pkg::LOSS_W-1:0];
                end
            end
        end
    end

    // Divider datapath and output register
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                // set up the mean update: |x - mean| / n
                r_dvd     <= DW'(w_mag);
                r_dsr     <= w_samples_inc;
                r_rem     <= '0;
                r_step    <= STEPW'(DW - 1);
                r_is_mean <= 1'b1;
                r_neg     <= (w_rtt < r_mean);
            end
            S_UNQ1: begin
                r_tmp <= (r_dup >= r_recv) ? '0 : r_recv - r_dup;
            end
            S_DIFF: begin
                r_tmp <= r_sent - r_uniq;
            end
            S_SCALE: begin
                // loss = (sent - unique) * 100 / sent
                r_dvd     <= DW'(r_tmp) * DW'(prs_pkg::PCT_SCALE);
                r_dsr     <= r_sent;
                r_rem     <= '0;
                r_step    <= STEPW'(DW - 1);
                r_is_mean <= 1'b0;
            end
            S_DIV: begin
                // shift one quotient bit into the dividend register
                r_dvd  <= n_dvd;
                r_rem  <= n_rem;
                r_step <= r_step - 1'b1;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out <= OUT_TW'({r_max, r_mean, r_min, (r_samples != '0), r_loss,
                                      r_uniq, r_unm, r_dup, r_recv, r_sent});
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;

`ifndef SYNTHESIS
    // unique replies never exceed the replies received
    a_uniq_le_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_uniq <= r_recv)
        else $error("unique replies exceed received");

    // loss stays a percentage
    a_loss_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loss <= prs_pkg::LOSS_W'(prs_pkg::PCT_SCALE))
        else $error("loss percent above 100");

    // running mean lies between minimum and maximum once settled
    a_mean_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_samples != '0) |->
            (r_min <= r_mean && r_mean <= r_max))
        else $error("running mean outside min/max");

    // partial remainder stays below a nonzero divisor
    a_rem_below_dsr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dsr != '0 && r_rem < r_dsr))
        else $error("divider remainder out of range");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for probe_reply_statistics_top: drives probe, reply and sample items and checks
// every result against a built-in model of the counters, loss percent and round trip stats.
// Depends on prs_pkg and the RTL of the block.
module tb;

    // Result item, declared high field first so its packed layout matches o_m_tdata
    typedef struct packed {
        logic [23:0] rtt_max;
        logic [23:0] rtt_mean;
        logic [23:0] rtt_min;
        logic        rtt_valid;
        logic [6:0]  loss_pct;
        logic [31:0] unique_n;
        logic [31:0] unmatched_n;
        logic [31:0] dup_n;
        logic [31:0] recv_n;
        logic [31:0] sent_n;
    } t_stats;

    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
    localparam int          IDLE_LIMIT = 3000;
    localparam int          TAIL_CYCLES = 60;
    localparam int          RANDOM_ITEMS = 1400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // rtt_ms
    logic [3:0]  i_s_tuser = '0;   // cmd[1:0], reply_status[3:2]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // sent_total, received_total, duplicate_total, unmatched_total, unique_replies,
    // loss_pct, rtt_valid, rtt_minimum, rtt_mean, rtt_maximum
    logic [$bits(t_stats)-1:0] o_m_tdata;

    // Model state of the block
    logic [31:0] sent_cnt, recv_cnt, dup_cnt, unm_cnt, sample_cnt;
    logic [23:0] rtt_lo, rtt_hi, rtt_avg;

    t_stats pending_stats[$];
    int     cmd_seen[4];
    int     items_sent;
    int     results_checked;
    int     mismatches;
    bit     tx_idle_on;
    bit     rx_idle_on;

    probe_reply_statistics_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sat_bump(logic [31:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 32'd1;
    endfunction

    // Advance the model by one event and return the totals it reports
    function automatic t_stats update_stats(prs_pkg::t_cmd cmd, prs_pkg::t_status status,
                                            logic [23:0] rtt);
        t_stats      r;
        logic [31:0] uniq;
        logic [31:0] step;
        if (cmd == prs_pkg::CMD_SENT) begin
            sent_cnt = sat_bump(sent_cnt);
        end else if (cmd == prs_pkg::CMD_REPLY) begin
            recv_cnt = sat_bump(recv_cnt);
            if (status == prs_pkg::ST_DUP)
                dup_cnt = sat_bump(dup_cnt);
            else if (status == prs_pkg::ST_UNMATCHED)
                unm_cnt = sat_bump(unm_cnt);
        end else if (cmd == prs_pkg::CMD_SAMPLE) begin
            if (sample_cnt == 0 || rtt < rtt_lo) rtt_lo = rtt;
            if (sample_cnt == 0 || rtt > rtt_hi) rtt_hi = rtt;
            sample_cnt = sat_bump(sample_cnt);
            // Signed step toward the sample, truncated toward zero
            if (rtt >= rtt_avg) begin
                step = {8'd0, rtt - rtt_avg} / sample_cnt;
                rtt_avg = rtt_avg + step[23:0];
            end else begin
                step = {8'd0, rtt_avg - rtt} / sample_cnt;
                rtt_avg = rtt_avg - step[23:0];
            end
        end
        if (dup_cnt >= recv_cnt || unm_cnt >= recv_cnt - dup_cnt)
            uniq = '0;
        else
            uniq = recv_cnt - dup_cnt - unm_cnt;
        r.sent_n      = sent_cnt;
        r.recv_n      = recv_cnt;
        r.dup_n       = dup_cnt;
        r.unmatched_n = unm_cnt;
        r.unique_n    = uniq;
        if (sent_cnt == 0 || uniq >= sent_cnt)
            r.loss_pct = '0;
        else
            r.loss_pct = 7'((64'(sent_cnt - uniq) * 64'd100) / 64'(sent_cnt));
        r.rtt_valid = (sample_cnt != 0);
        r.rtt_min   = rtt_lo;
        r.rtt_mean  = rtt_avg;
        r.rtt_max   = rtt_hi;
        return r;
    endfunction

    // Mostly short gaps, a few long ones; none when idling is switched off
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [23:0] pick_rtt();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 255));
            1: return 24'($urandom_range(256, 65535));
            2: return 24'($urandom);
            default: return 24'($urandom) & 24'((32'd1 << $urandom_range(1, 24)) - 1);
        endcase
    endfunction

    // Present one item, hold it until accepted, then record its expected result
    task automatic send_event(prs_pkg::t_cmd cmd, prs_pkg::t_status status, logic [23:0] rtt);
        int gap;
        gap = pick_gap(tx_idle_on);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tuser  <= {status, cmd};
        i_s_tdata  <= rtt;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_stats.push_back(update_stats(cmd, status, rtt));
        cmd_seen[cmd]++;
        items_sent++;
    endtask

    task automatic wait_drained();
        while (pending_stats.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls on tready
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                hold--;
            end else begin
                i_m_tready <= 1'b1;
                hold = pick_gap(rx_idle_on);
            end
        end
    end

    function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("tb: mismatch on %s at result %0d: expected %0d (0x%0h), got %0d (0x%0h)",
                         label, results_checked, want, want, got, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted result with the oldest expectation
    initial begin
        t_stats got, want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got = t_stats'(o_m_tdata);
                if (pending_stats.size() == 0) begin
                    if (mismatches < 10)
                        $display("tb: result arrived with nothing expected");
                    mismatches++;
                end else begin
                    want = pending_stats.pop_front();
                    check_field("sent_total", want.sent_n, got.sent_n);
                    check_field("received_total", want.recv_n, got.recv_n);
                    check_field("duplicate_total", want.dup_n, got.dup_n);
                    check_field("unmatched_total", want.unmatched_n, got.unmatched_n);
                    check_field("unique_replies", want.unique_n, got.unique_n);
                    check_field("loss_pct", 32'(want.loss_pct), 32'(got.loss_pct));
                    check_field("rtt_valid", 32'(want.rtt_valid), 32'(got.rtt_valid));
                    check_field("rtt_minimum", 32'(want.rtt_min), 32'(got.rtt_min));
                    check_field("rtt_mean", 32'(want.rtt_mean), 32'(got.rtt_mean));
                    check_field("rtt_maximum", 32'(want.rtt_max), 32'(got.rtt_max));
                end
                results_checked++;
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: timeout, no item moved for %0d cycles", IDLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    // Unused command right after reset returns all-zero totals and no rtt
    task automatic test_empty_state();
        send_event(prs_pkg::CMD_NONE, prs_pkg::t_status'(2'd3), 24'hFF_FFFF);
    endtask

    // Loss from full to none, every reply class, unknown status as a first answer
    task automatic test_loss_and_replies();
        send_event(prs_pkg::CMD_SENT, prs_pkg::ST_FIRST, 24'h0);
        send_event(prs_pkg::CMD_SENT, prs_pkg::t_status'(2'd3), 24'hFF_FFFF);
        send_event(prs_pkg::CMD_REPLY, prs_pkg::ST_FIRST, 24'h0);
        send_event(prs_pkg::CMD_REPLY, prs_pkg::ST_DUP, 24'h0);
        send_event(prs_pkg::CMD_REPLY, prs_pkg::ST_UNMATCHED, 24'h0);
        send_event(prs_pkg::CMD_REPLY, prs_pkg::t_status'(2'd3), 24'h0);
        send_event(prs_pkg::CMD_SENT, prs_pkg::ST_FIRST, 24'h0);
        send_event(prs_pkg::CMD_REPLY, prs_pkg::ST_DUP, 24'h0);
        send_event(prs_pkg::CMD_REPLY, prs_pkg::ST_DUP, 24'h0);
        send_event(prs_pkg::CMD_SENT, prs_pkg::ST_UNMATCHED, 24'h0);
    endtask

    // Round trip extremes, mean moving down and up
    task automatic test_rtt_extremes();
        send_event(prs_pkg::CMD_SAMPLE, prs_pkg::ST_FIRST, 24'hFF_FFFF);
        send_event(prs_pkg::CMD_SAMPLE, prs_pkg::ST_FIRST, 24'h00_0000);
        send_event(prs_pkg::CMD_SAMPLE, prs_pkg::t_status'(2'd3), 24'h00_0100);
        send_event(prs_pkg::CMD_SAMPLE, prs_pkg::ST_DUP, 24'hAA_AAAA);
        send_event(prs_pkg::CMD_SAMPLE, prs_pkg::ST_UNMATCHED, 24'h55_5555);
        send_event(prs_pkg::CMD_SAMPLE, prs_pkg::ST_FIRST, 24'hFF_FFFF);
        send_event(prs_pkg::CMD_NONE, prs_pkg::ST_DUP, 24'h12_3456);
    endtask

    // Probe sessions with random content, plus noise items
    task automatic test_random_traffic(int n_items);
        int stop_at;
        int next_mode;
        stop_at   = items_sent + n_items;
        next_mode = items_sent;
        while (items_sent < stop_at) begin
            // Switch idling on and off on either side now and then
            if (items_sent >= next_mode) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                next_mode  = items_sent + $urandom_range(60, 200);
            end
            if ($urandom_range(0, 99) < 78) begin
                send_event(prs_pkg::CMD_SENT, prs_pkg::t_status'($urandom_range(0, 3)),
                           24'($urandom));
                if ($urandom_range(0, 9) < 8) begin
                    case ($urandom_range(0, 19))
                        0: send_event(prs_pkg::CMD_REPLY, prs_pkg::ST_UNMATCHED,
                                      24'($urandom));
                        1: send_event(prs_pkg::CMD_REPLY, prs_pkg::t_status'(2'd3),
                                      24'($urandom));
                        default: send_event(prs_pkg::CMD_REPLY, prs_pkg::ST_FIRST,
                                            24'($urandom));
                    endcase
                    if ($urandom_range(0, 9) == 0)
                        send_event(prs_pkg::CMD_REPLY, prs_pkg::ST_DUP, 24'($urandom));
                    send_event(prs_pkg::CMD_SAMPLE, prs_pkg::t_status'($urandom_range(0, 3)),
                               pick_rtt());
                end
            end else begin
                send_event(prs_pkg::t_cmd'($urandom_range(0, 3)),
                           prs_pkg::t_status'($urandom_range(0, 3)), 24'($urandom));
            end
        end
    endtask

    // Hold the sender until every result is back, then resume
    task automatic test_drain_pause();
        send_event(prs_pkg::CMD_SENT, prs_pkg::ST_FIRST, 24'h0);
        send_event(prs_pkg::CMD_SAMPLE, prs_pkg::ST_FIRST, pick_rtt());
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_drained();
        send_event(prs_pkg::CMD_REPLY, prs_pkg::ST_FIRST, 24'h0);
        send_event(prs_pkg::CMD_SAMPLE, prs_pkg::ST_FIRST, pick_rtt());
    endtask

    initial begin
        sent_cnt   = '0;
        recv_cnt   = '0;
        dup_cnt    = '0;
        unm_cnt    = '0;
        sample_cnt = '0;
        rtt_lo     = '0;
        rtt_hi     = '0;
        rtt_avg    = '0;
        items_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        foreach (cmd_seen[i]) cmd_seen[i] = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_state();
        test_loss_and_replies();
        test_rtt_extremes();
        test_drain_pause();
        test_random_traffic(RANDOM_ITEMS / 2);
        test_drain_pause();
        test_random_traffic(RANDOM_ITEMS / 2);

        // Drop valid, wait for the last results, then watch for strays
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d items: %0d probes, %0d replies, %0d rtt samples, %0d unused",
                 items_sent, cmd_seen[prs_pkg::CMD_SENT], cmd_seen[prs_pkg::CMD_REPLY],
                 cmd_seen[prs_pkg::CMD_SAMPLE], cmd_seen[prs_pkg::CMD_NONE]);
        $display("tb: %0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending_stats.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
